/* rtl/pdtq_pkg.sv */
// ============================================================================
// pdtq_pkg: shared types and constants of the deferred task queue
// Operation and status codes, the command and result records passed between
// the top level and the controller, and the layout of one stored entry.
// ============================================================================
package pdtq_pkg;

  // Default geometry: number of priority levels and ring depth per level.
  localparam int NUM_LEVELS_DEF  = 4;
  localparam int LEVEL_DEPTH_DEF = 16;

  // Fixed field widths of the interface.
  localparam int FUNC_W = 2;
  localparam int ID_W   = 16;
  localparam int PRIO_W = 2;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] CFG_LIMIT_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQUEUE  = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_CANCEL   = 2'd2,
    FUNC_SHUTDOWN = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_STOPPED    = 3'd2,
    ST_DISPATCHED = 3'd3,
    ST_NONE_DUE   = 3'd4,
    ST_CANCEL     = 3'd5,
    ST_SHUTDOWN   = 3'd6
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  priority_req;
    logic [TIME_W-1:0]  ready_time;
    logic [TIME_W-1:0]  now_time;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_W-1:0]   count;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  ready;
  } entry_t;

endpackage

/* rtl/pdtq_entry_ram.sv */
// ============================================================================
// pdtq_entry_ram: entry storage for all priority rings
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued. Address is {level, slot}.
// ============================================================================
module pdtq_entry_ram #(
  parameter int NUM_LEVELS  = pdtq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = pdtq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rd_en,
  input  logic [$clog2(NUM_LEVELS)+$clog2(LEVEL_DEPTH)-1:0]   rd_addr,
  output pdtq_pkg::entry_t                                    rd_data,
  input  logic                                                wr_en,
  input  logic [$clog2(NUM_LEVELS)+$clog2(LEVEL_DEPTH)-1:0]   wr_addr,
  input  pdtq_pkg::entry_t                                    wr_data
);
  import pdtq_pkg::*;

  localparam int WORDS = NUM_LEVELS * (2 ** $clog2(LEVEL_DEPTH));

  entry_t mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pdtq_ctrl.sv */
// ============================================================================
// pdtq_ctrl: operation sequencer and ring pointers
// Holds head, tail and count of every level ring, the running flag and the
// total count, and walks the entry memory for dispatch and cancel.
// ============================================================================
module pdtq_ctrl #(
  parameter int NUM_LEVELS  = pdtq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = pdtq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cmd_valid,
  input  pdtq_pkg::cmd_t                                      cmd,
  output logic                                                cmd_ready,
  input  logic [pdtq_pkg::CNT_W-1:0]                          max_total,
  output logic                                                res_valid,
  output pdtq_pkg::res_t                                      res,
  input  logic                                                res_ready,
  output logic                                                mem_rd_en,
  output logic [$clog2(NUM_LEVELS)+$clog2(LEVEL_DEPTH)-1:0]   mem_rd_addr,
  input  pdtq_pkg::entry_t                                    mem_rd_data,
  output logic                                                mem_wr_en,
  output logic [$clog2(NUM_LEVELS)+$clog2(LEVEL_DEPTH)-1:0]   mem_wr_addr,
  output pdtq_pkg::entry_t                                    mem_wr_data
);
  import pdtq_pkg::*;

  localparam int LW   = $clog2(NUM_LEVELS);
  localparam int SW   = $clog2(LEVEL_DEPTH);
  localparam int CW   = $clog2(LEVEL_DEPTH + 1);
  localparam int TW   = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
  localparam int CMPW = (TW > CNT_W) ? TW : CNT_W;
  localparam int PW   = ((LW > PRIO_W) ? LW : PRIO_W) + 1;
  localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_DISP_RD  = 6'b000100,
    S_DISP_CHK = 6'b001000,
    S_CAN_RD   = 6'b010000,
    S_CAN_WR   = 6'b100000
  } state_t;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(LEVEL_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  // Ring offset: slot plus offset stays below twice the depth, so one subtract wraps it.
  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] s, input logic [CW-1:0] d);
    logic [SW:0] sum;
    sum = (SW+1)'(s) + (SW+1)'(d);
    if (sum >= (SW+1)'(LEVEL_DEPTH)) begin
      sum = sum - (SW+1)'(LEVEL_DEPTH);
    end
    return sum[SW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [TW-1:0] v);
    logic [CMPW-1:0] w;
    w = CMPW'(v);
    return (w > CMPW'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(w);
  endfunction

  state_t        state, state_next;
  cmd_t          cmd_q;
  logic          running, running_next;
  logic [SW-1:0] head [NUM_LEVELS];
  logic [SW-1:0] head_next [NUM_LEVELS];
  logic [SW-1:0] tail [NUM_LEVELS];
  logic [SW-1:0] tail_next [NUM_LEVELS];
  logic [CW-1:0] cnt [NUM_LEVELS];
  logic [CW-1:0] cnt_next [NUM_LEVELS];
  logic [TW-1:0] total, total_next;
  logic [LW-1:0] lvl, lvl_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] n, n_next;
  logic [TW-1:0] removed, removed_next;
  logic          fin;
  logic          wr_req;
  logic          commit;
  logic [PW-1:0] prio_ext;
  logic [LW-1:0] enq_lvl;

  assign prio_ext  = PW'(cmd_q.priority_req);
  assign enq_lvl   = (prio_ext >= PW'(NUM_LEVELS)) ? LAST_LVL : LW'(prio_ext);
  assign cmd_ready = (state == S_IDLE);
  assign res_valid = fin;
  // A finishing step waits, with no side effect, until its result can be taken.
  assign commit    = !fin || res_ready;
  assign mem_wr_en = wr_req && commit;

  always_comb begin
    state_next   = state;
    running_next = running;
    head_next    = head;
    tail_next    = tail;
    cnt_next     = cnt;
    total_next   = total;
    lvl_next     = lvl;
    k_next       = k;
    n_next       = n;
    removed_next = removed;
    fin          = 1'b0;
    res          = '0;
    res.status   = ST_ACCEPTED;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = {lvl, head[lvl]};
    wr_req       = 1'b0;
    mem_wr_addr  = {lvl, tail[lvl]};
    mem_wr_data  = mem_rd_data;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          lvl_next     = '0;
          k_next       = '0;
          n_next       = '0;
          removed_next = '0;
          unique case (cmd.func)
            FUNC_ENQUEUE, FUNC_SHUTDOWN: state_next = S_EXEC;
            FUNC_DISPATCH:               state_next = S_DISP_RD;
            FUNC_CANCEL:                 state_next = S_CAN_RD;
            default:                     state_next = S_IDLE;
          endcase
        end
      end

      S_EXEC: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        res.count  = sat_cnt(total);
        if (cmd_q.func == FUNC_ENQUEUE) begin
          if (!running) begin
            res.status = ST_STOPPED;
          end else if (CMPW'(total) >= CMPW'(max_total) ||
                       cnt[enq_lvl] >= CW'(LEVEL_DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            res.status         = ST_ACCEPTED;
            wr_req             = 1'b1;
            mem_wr_addr        = {enq_lvl, tail[enq_lvl]};
            mem_wr_data.id     = cmd_q.task_id;
            mem_wr_data.ready  = cmd_q.ready_time;
            tail_next[enq_lvl] = slot_inc(tail[enq_lvl]);
            cnt_next[enq_lvl]  = cnt[enq_lvl] + 1'b1;
            total_next         = total + 1'b1;
            res.count          = sat_cnt(total + 1'b1);
          end
        end else begin
          res.status   = ST_SHUTDOWN;
          running_next = 1'b0;
          total_next   = '0;
          for (int i = 0; i < NUM_LEVELS; i++) begin
            head_next[i] = '0;
            tail_next[i] = '0;
            cnt_next[i]  = '0;
          end
        end
      end

      S_DISP_RD: begin
        if (cnt[lvl] == '0) begin
          if (lvl == LAST_LVL) begin
            fin        = 1'b1;
            res.status = ST_NONE_DUE;
            res.count  = sat_cnt(total);
            state_next = S_IDLE;
          end else begin
            lvl_next = lvl + 1'b1;
          end
        end else begin
          mem_rd_en  = 1'b1;
          state_next = S_DISP_CHK;
        end
      end

      S_DISP_CHK: begin
        head_next[lvl] = slot_inc(head[lvl]);
        if (mem_rd_data.ready > cmd_q.now_time) begin
          // Not yet due: the front goes to the back of its own ring.
          wr_req         = 1'b1;
          tail_next[lvl] = slot_inc(tail[lvl]);
          if (lvl == LAST_LVL) begin
            fin        = 1'b1;
            res.status = ST_NONE_DUE;
            res.count  = sat_cnt(total);
            state_next = S_IDLE;
          end else begin
            lvl_next   = lvl + 1'b1;
            state_next = S_DISP_RD;
          end
        end else begin
          fin           = 1'b1;
          cnt_next[lvl] = cnt[lvl] - 1'b1;
          total_next    = total - 1'b1;
          res.status    = ST_DISPATCHED;
          res.task_id   = mem_rd_data.id;
          res.prio      = PRIO_W'(lvl);
          res.count     = sat_cnt(total - 1'b1);
          state_next    = S_IDLE;
        end
      end

      S_CAN_RD: begin
        if (k == cnt[lvl]) begin
          tail_next[lvl] = slot_add(head[lvl], n);
          cnt_next[lvl]  = n;
          k_next         = '0;
          n_next         = '0;
          if (lvl == LAST_LVL) begin
            fin        = 1'b1;
            res.status = ST_CANCEL;
            res.count  = sat_cnt(removed);
            total_next = total - removed;
            state_next = S_IDLE;
          end else begin
            lvl_next = lvl + 1'b1;
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {lvl, slot_add(head[lvl], k)};
          state_next  = S_CAN_WR;
        end
      end

      S_CAN_WR: begin
        // Survivors are packed from the head; the write slot never passes the read slot.
        if (mem_rd_data.id == cmd_q.task_id) begin
          removed_next = removed + 1'b1;
        end else begin
          wr_req      = 1'b1;
          mem_wr_addr = {lvl, slot_add(head[lvl], n)};
          n_next      = n + 1'b1;
        end
        k_next     = k + 1'b1;
        state_next = S_CAN_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= 1'b1;
      total   <= '0;
      lvl     <= '0;
      k       <= '0;
      n       <= '0;
      removed <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
    end else if (commit) begin
      state   <= state_next;
      running <= running_next;
      total   <= total_next;
      lvl     <= lvl_next;
      k       <= k_next;
      n       <= n_next;
      removed <= removed_next;
      head    <= head_next;
      tail    <= tail_next;
      cnt     <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

endmodule

/* rtl/priority_deferred_task_queue_core.sv */
// ============================================================================
// priority_deferred_task_queue_core: strict priority queue of deferred tasks
// One ring per priority level in a shared entry memory; enqueue, dispatch,
// cancel by id and shutdown, one result per operation.
// ============================================================================
// Usage. The input channel carries one operation per transfer (func, task_id,
// priority_req, ready_time, now_time); the output channel returns exactly one
// result per operation (status, out_task_id, out_priority, entry_count), in
// order. Both channels use valid and stall. The limit register is written
// through cfg_wr_en / cfg_wr_data; the user must do so only while no
// operation is in flight, as the block itself does not enforce this.
// Sequencing. An operation is taken and worked on alone. Enqueue and shutdown
// finish in the execute state after the take. Dispatch skips empty levels and
// reads, then checks, each other level front until one is due; cancel reads
// each queued entry of every level and writes the survivors back, since the
// entry memory has a single read port with registered data.
// Reset. All rings are empty, the block is running and the limit is 64; the
// entry memory needs no clearing, since only live ring slots are ever read.
// Stall. The result register holds a finished result while the receiver
// stalls; the next operation is still taken and worked on, and its final
// step waits until the result register frees up.
// ============================================================================
module priority_deferred_task_queue_core #(
  parameter int NUM_LEVELS  = pdtq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = pdtq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          cfg_wr_en,
  input  logic [pdtq_pkg::CNT_W-1:0]    cfg_wr_data,
  // Operation channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pdtq_pkg::FUNC_W-1:0]   func,
  input  logic [pdtq_pkg::ID_W-1:0]     task_id,
  input  logic [pdtq_pkg::PRIO_W-1:0]   priority_req,
  input  logic [pdtq_pkg::TIME_W-1:0]   ready_time,
  input  logic [pdtq_pkg::TIME_W-1:0]   now_time,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [pdtq_pkg::ID_W-1:0]     out_task_id,
  output logic [pdtq_pkg::PRIO_W-1:0]   out_priority,
  output logic [pdtq_pkg::CNT_W-1:0]    entry_count
);
  import pdtq_pkg::*;

  localparam int AW = $clog2(NUM_LEVELS) + $clog2(LEVEL_DEPTH);

  logic [CNT_W-1:0] max_total;
  cmd_t             cmd;
  logic             cmd_ready;
  res_t             res;
  logic             res_valid;
  logic             out_free;
  logic             out_load;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  entry_t           mem_rd_data;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  entry_t           mem_wr_data;

  // The limit register: written whenever the enable is high, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_total <= CFG_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_total <= cfg_wr_data;
    end
  end

  always_comb begin
    cmd.func         = func_t'(func);
    cmd.task_id      = task_id;
    cmd.priority_req = priority_req;
    cmd.ready_time   = ready_time;
    cmd.now_time     = now_time;
  end

  // The controller only takes an operation in its idle state.
  assign in_stall = !cmd_ready;

  pdtq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (in_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .max_total   (max_total),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (out_free),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  pdtq_entry_ram #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Result register. It can take a new result when it is empty, or when its
  // current result is leaving in this cycle through a completed transfer.
  assign out_free = !out_valid || !out_stall;
  assign out_load = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res.status;
      out_task_id  <= res.task_id;
      out_priority <= res.prio;
      entry_count  <= res.count;
    end
  end

  // An operation keeps the input stalled in the cycle after it is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("operation taken in the cycle after another");

  // A result is only ever produced while an operation is in progress.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("result produced with no operation in progress");

  // Only a dispatch reports a task id and a level.
  a_id_only_on_dispatch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DISPATCHED) |-> (out_task_id == '0 && out_priority == '0))
    else $error("task id or level reported outside a dispatch");

  // A fresh result is loaded only when the register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(status) && $stable(entry_count)))
    else $error("pending result overwritten");

endmodule
